// ===== hdl/dhc_pkg.sv =====
// ----------------------------------------------------------------------------
// dhc_pkg
// Types and codes shared by the detector hit clusterer modules.
// ----------------------------------------------------------------------------
package dhc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 40;

  localparam logic [CfgIdxW-1:0] CFG_TIME_LIMIT     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BULK_DISTANCE  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SURFACE_LIMIT  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SURFACE_THICK  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SURFACE_ENABLE = 3'd4;

  localparam logic CMD_HIT   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [30:0]        track_number;
    logic [30:0]        detector_number;
    logic [39:0]        hit_time;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic [23:0]        depth;
    logic [23:0]        energy;
  } in_item_t;

  typedef struct packed {
    logic [30:0] out_track;
    logic [30:0] out_detector;
    logic [39:0] start_time;
    logic [31:0] energy_sum;
    logic [15:0] hit_count;
    logic [31:0] first_index;
  } out_item_t;

  typedef struct packed {
    logic [39:0] time_limit;
    logic [39:0] bulk_sq;
    logic [39:0] surface_sq;
    logic [23:0] surf_thick;
    logic        surface_enable;
  } cfg_t;

  typedef struct packed {
    logic               open;
    logic [30:0]        track;
    logic [30:0]        detector;
    logic [39:0]        time_val;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
    logic               in_surface;
  } cluster_t;

  typedef struct packed {
    logic start_new;
    logic in_surf;
  } join_t;

endpackage

// ===== hdl/dhc_join.sv =====
// ----------------------------------------------------------------------------
// dhc_join
// Decides whether a hit joins the open cluster or starts a new one.
// ----------------------------------------------------------------------------
module dhc_join (
  input  dhc_pkg::in_item_t hit,
  input  dhc_pkg::cluster_t clu,
  input  dhc_pkg::cfg_t     cfg,
  output dhc_pkg::join_t    dec
);
  import dhc_pkg::*;

  function automatic logic [47:0] sq_diff(input logic signed [23:0] a,
                                          input logic signed [23:0] b);
    logic signed [24:0] d;
    logic [24:0]        m;
    d = {a[23], a} - {b[23], b};
    m = d[24] ? 25'(-d) : 25'(d);
    return {24'd0, m[23:0]} * {24'd0, m[23:0]};
  endfunction

  logic [47:0] sq_x, sq_y, sq_z;
  logic [49:0] d2;
  logic [39:0] gap;
  logic [39:0] thr_sq;
  logic        surf_hit;
  logic        differs;

  always_comb begin
    surf_hit = cfg.surface_enable && (hit.depth < cfg.surf_thick);
    gap = (hit.hit_time > clu.time_val) ? hit.hit_time - clu.time_val
                                        : clu.time_val - hit.hit_time;
    sq_x = sq_diff(hit.pos_x, clu.pos_x);
    sq_y = sq_diff(hit.pos_y, clu.pos_y);
    sq_z = sq_diff(hit.pos_z, clu.pos_z);
    d2 = {2'b00, sq_x} + {2'b00, sq_y} + {2'b00, sq_z};
    thr_sq = surf_hit ? cfg.surface_sq : cfg.bulk_sq;
    differs = !clu.open || (hit.track_number != clu.track) ||
              (hit.detector_number != clu.detector) || (gap > cfg.time_limit) ||
              (surf_hit != clu.in_surface) || (d2 >= {10'd0, thr_sq});
    dec.start_new = differs;
    dec.in_surf   = surf_hit;
  end

endmodule

// ===== hdl/detector_hit_clusterer_unit.sv =====
// ----------------------------------------------------------------------------
// detector_hit_clusterer_unit
// Groups a track-ordered stream of detector hits into clusters.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes hit and flush requests.
// A hit either joins the open cluster or closes it and opens a new one;
// a flush closes the open cluster and restarts the hit sequence number.
// Each closed cluster leaves as one request on the output channel
// (out_valid/out_ready/out_data).
// A request is captured in an input register, decided against the open
// cluster, and the cluster that it closes, if any, is loaded into the output register.
// Throughput is one request per cycle unless a result stalls; the decision
// path is three 24x24 squares, their sum and a compare against a squared
// threshold held in the configuration registers.
// When the receiver stalls with a result waiting, the pending request holds
// in the input register and in_ready drops until the result is taken.
// Reset clears the configuration, the open cluster and the sequence number.
// cfg_we/cfg_idx/cfg_wdata write one register per cycle; the user must write them only while idle (not enforced).
// ----------------------------------------------------------------------------
module detector_hit_clusterer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dhc_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dhc_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [dhc_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [dhc_pkg::CfgDataW-1:0]    cfg_wdata
);
  import dhc_pkg::*;

  cfg_t      cfg_r;
  in_item_t  in_r;
  logic      in_valid_r;
  cluster_t  clu_r, clu_nxt;
  logic [31:0] energy_acc_r, energy_acc_nxt;
  logic [15:0] count_acc_r, count_acc_nxt;
  logic [31:0] hit_seq_r, hit_seq_nxt;
  logic [31:0] first_seq_r, first_seq_nxt;
  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;
  join_t     dec;
  logic      proc_go;
  logic      emit;
  logic [32:0] energy_sum;

  dhc_join u_join (
    .hit (in_r),
    .clu (clu_r),
    .cfg (cfg_r),
    .dec (dec)
  );

  assign proc_go  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || proc_go;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_TIME_LIMIT:     cfg_r.time_limit <= cfg_wdata;
        CFG_BULK_DISTANCE:  cfg_r.bulk_sq <= {20'd0, cfg_wdata[19:0]} *
                                             {20'd0, cfg_wdata[19:0]};
        CFG_SURFACE_LIMIT:  cfg_r.surface_sq <= {20'd0, cfg_wdata[19:0]} *
                                                {20'd0, cfg_wdata[19:0]};
        CFG_SURFACE_THICK:  cfg_r.surf_thick <= cfg_wdata[23:0];
        CFG_SURFACE_ENABLE: cfg_r.surface_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    clu_nxt        = clu_r;
    energy_acc_nxt = energy_acc_r;
    count_acc_nxt  = count_acc_r;
    hit_seq_nxt    = hit_seq_r;
    first_seq_nxt  = first_seq_r;
    emit           = 1'b0;
    energy_sum     = {1'b0, energy_acc_r} + {9'd0, in_r.energy};
    out_nxt.out_track    = clu_r.track;
    out_nxt.out_detector = clu_r.detector;
    out_nxt.start_time   = clu_r.time_val;
    out_nxt.energy_sum   = energy_acc_r;
    out_nxt.hit_count    = count_acc_r;
    out_nxt.first_index  = first_seq_r;
    if (proc_go) begin
      if (in_r.cmd == CMD_FLUSH) begin
        emit         = clu_r.open;
        clu_nxt.open = 1'b0;
        hit_seq_nxt  = '0;
      end else begin
        hit_seq_nxt = hit_seq_r + 32'd1;
        if (dec.start_new) begin
          emit               = clu_r.open;
          clu_nxt.open       = 1'b1;
          clu_nxt.track      = in_r.track_number;
          clu_nxt.detector   = in_r.detector_number;
          clu_nxt.time_val   = in_r.hit_time;
          clu_nxt.pos_x      = in_r.pos_x;
          clu_nxt.pos_y      = in_r.pos_y;
          clu_nxt.pos_z      = in_r.pos_z;
          clu_nxt.in_surface = dec.in_surf;
          energy_acc_nxt     = {8'd0, in_r.energy};
          count_acc_nxt      = 16'd1;
          first_seq_nxt      = hit_seq_r;
        end else begin
          energy_acc_nxt = energy_sum[32] ? '1 : energy_sum[31:0];
          if (count_acc_r != '1) begin
            count_acc_nxt = count_acc_r + 16'd1;
          end
        end
      end
    end
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clu_r       <= '0;
      hit_seq_r   <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      clu_r       <= clu_nxt;
      hit_seq_r   <= hit_seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (emit) begin
      out_r <= out_nxt;
    end
    energy_acc_r     <= energy_acc_nxt;
    count_acc_r      <= count_acc_nxt;
    first_seq_r      <= first_seq_nxt;
  end

  a_flush_closes: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && in_r.cmd == CMD_FLUSH |=> !clu_r.open && hit_seq_r == '0)
    else $error("flush did not close the cluster");

  a_open_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
    clu_r.open |-> count_acc_r != '0)
    else $error("open cluster with zero hits");

  a_emit_from_open: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(clu_r.open))
    else $error("result produced without an open cluster");

  a_first_seq: assert property (@(posedge clk) disable iff (!rst_n)
    proc_go && in_r.cmd == CMD_HIT && dec.start_new
      |=> first_seq_r == $past(hit_seq_r) && clu_r.open)
    else $error("new cluster lost its first sequence number");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("request taken while result stalled with input full");

endmodule

// ===== test/detector_hit_clusterer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// detector_hit_clusterer_unit_tb
// Self-checking bench for the detector hit clusterer.
// Requests pass through a valid/ready sender into the unit, and a cluster
// model in the bench predicts every closed cluster. It covers directed
// corner requests, several register settings and random hit streams built
// around a moving base hit. It also covers a long run that
// saturates the energy sum, random idling on both sides, a
// long receiver hold-off and drain pauses.
// ----------------------------------------------------------------------------
module detector_hit_clusterer_unit_tb;
  import dhc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class cluster_checker;
    logic [39:0]        lim_t;
    logic [19:0]        lim_bulk;
    logic [19:0]        lim_surf;
    logic [23:0]        thick;
    logic               surf_on;
    logic               open_q;
    logic [30:0]        anchor_trk;
    logic [30:0]        anchor_det;
    logic [39:0]        anchor_t;
    logic signed [23:0] anchor_pos [3];
    logic               anchor_surf;
    logic [31:0]        esum;
    logic [15:0]        nhits;
    logic [31:0]        seq_ctr;
    logic [31:0]        anchor_seq;
    out_item_t          closed_clusters [$];
    int                 errors;

    function new();
      lim_t = '0;
      lim_bulk = '0;
      lim_surf = '0;
      thick = '0;
      surf_on = 1'b0;
      open_q = 1'b0;
      anchor_trk = '0;
      anchor_det = '0;
      anchor_t = '0;
      anchor_pos = '{default: '0};
      anchor_surf = 1'b0;
      esum = '0;
      nhits = '0;
      seq_ctr = '0;
      anchor_seq = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_TIME_LIMIT:     lim_t = val;
        CFG_BULK_DISTANCE:  lim_bulk = val[19:0];
        CFG_SURFACE_LIMIT:  lim_surf = val[19:0];
        CFG_SURFACE_THICK:  thick = val[23:0];
        CFG_SURFACE_ENABLE: surf_on = val[0];
        default: ;
      endcase
    endfunction

    function out_item_t closing();
      out_item_t c;
      c.out_track = anchor_trk;
      c.out_detector = anchor_det;
      c.start_time = anchor_t;
      c.energy_sum = esum;
      c.hit_count = nhits;
      c.first_index = anchor_seq;
      return c;
    endfunction

    function void note_request(in_item_t r);
      logic               surf;
      logic               split;
      logic signed [23:0] p [3];
      longint unsigned    gap;
      longint unsigned    d2;
      longint unsigned    thr;
      longint unsigned    sum;
      longint             d;
      if (r.cmd == CMD_FLUSH) begin
        if (open_q) closed_clusters = {closed_clusters, closing()};
        open_q = 1'b0;
        seq_ctr = '0;
        return;
      end
      p[0] = r.pos_x;
      p[1] = r.pos_y;
      p[2] = r.pos_z;
      surf = surf_on && (r.depth < thick);
      split = !open_q || r.track_number != anchor_trk || r.detector_number != anchor_det;
      gap = (r.hit_time > anchor_t) ? r.hit_time - anchor_t : anchor_t - r.hit_time;
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        d = $signed(p[i]) - $signed(anchor_pos[i]);
        d2 += d * d;
      end
      thr = surf ? lim_surf : lim_bulk;
      if (!split && gap > lim_t) split = 1'b1;
      if (!split && (surf != anchor_surf || d2 >= thr * thr)) split = 1'b1;
      if (split) begin
        if (open_q) closed_clusters = {closed_clusters, closing()};
        open_q = 1'b1;
        anchor_trk = r.track_number;
        anchor_det = r.detector_number;
        anchor_t = r.hit_time;
        anchor_pos = p;
        anchor_surf = surf;
        esum = r.energy;
        nhits = 16'd1;
        anchor_seq = seq_ctr;
      end else begin
        sum = esum + r.energy;
        esum = (sum > 64'hFFFF_FFFF) ? '1 : sum[31:0];
        if (nhits != '1) nhits++;
      end
      seq_ctr++;
    endfunction

    function void cmp(string fld, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fld, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (closed_clusters.size() == 0) begin
        $display("%0t: unexpected cluster, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = closed_clusters.pop_front();
      cmp("out_track", want.out_track, got.out_track);
      cmp("out_detector", want.out_detector, got.out_detector);
      cmp("start_time", want.start_time, got.start_time);
      cmp("energy_sum", want.energy_sum, got.energy_sum);
      cmp("hit_count", want.hit_count, got.hit_count);
      cmp("first_index", want.first_index, got.first_index);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CFG_TIME_LIMIT;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  cluster_checker chk = new();
  logic [CfgIdxW-1:0] reg_order [5] = '{CFG_TIME_LIMIT, CFG_BULK_DISTANCE,
                                        CFG_SURFACE_LIMIT, CFG_SURFACE_THICK,
                                        CFG_SURFACE_ENABLE};
  logic [39:0] cur_tl = '0;
  logic [19:0] cur_bulk = '0;
  logic [19:0] cur_surf = '0;
  logic [23:0] cur_thick = '0;
  logic        cur_en = 1'b0;
  logic        no_idle = 1'b0;
  int          sink_hold_req = 0;
  in_item_t    base = '0;

  detector_hit_clusterer_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic in_item_t random_req();
    logic [255:0] raw;
    in_item_t     h;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom()};
    h = raw[$bits(in_item_t)-1:0];
    h.cmd = CMD_HIT;
    return h;
  endfunction

  function automatic in_item_t flush_req();
    in_item_t h;
    h = random_req();
    h.cmd = CMD_FLUSH;
    return h;
  endfunction

  function automatic in_item_t make_hit(int trk, int det, longint t, int x, int y, int z,
                                        int dep, int en);
    in_item_t h;
    h.cmd = CMD_HIT;
    h.track_number = 31'(trk);
    h.detector_number = 31'(det);
    h.hit_time = 40'(t);
    h.pos_x = 24'(x);
    h.pos_y = 24'(y);
    h.pos_z = 24'(z);
    h.depth = 24'(dep);
    h.energy = 24'(en);
    return h;
  endfunction

  function automatic int wobble(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  // Mostly hits near the current base hit; some noise, new tracks and flushes.
  function automatic in_item_t next_hit();
    in_item_t h;
    int       r;
    int       ts;
    int       ds;
    r = $urandom_range(99);
    if (r < 5) return flush_req();
    h = random_req();
    if (r < 15) begin
      base = h;
      return h;
    end
    h.track_number = base.track_number;
    h.detector_number = base.detector_number;
    if (r < 19) h.track_number = base.track_number + 31'd1;
    else if (r < 23) h.detector_number = 31'($urandom());
    ts = (cur_tl > 40'd4000) ? 4000 : int'(cur_tl);
    h.hit_time = base.hit_time + 40'(wobble(ts + 1));
    ds = (cur_bulk > cur_surf) ? int'(cur_bulk) : int'(cur_surf);
    ds = ds * 2 / 3 + 2;
    h.pos_x = base.pos_x + 24'(wobble(ds));
    h.pos_y = base.pos_y + 24'(wobble(ds));
    h.pos_z = base.pos_z + 24'(wobble(ds));
    if ($urandom_range(3) != 0) h.depth = base.depth;
    else if (cur_en) h.depth = 24'($urandom_range(0, 2 * cur_thick + 1));
    if ($urandom_range(9) == 0) h.energy = '1;
    if (r < 25) base = h;
    return h;
  endfunction

  task automatic send(in_item_t r);
    if (!no_idle && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chk.note_request(r);
  endtask

  // Hold off the sender until every expected cluster has left the unit.
  task automatic drain();
    in_valid <= 1'b0;
    while (chk.closed_clusters.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_cfg(logic [39:0] tl, logic [19:0] bulk, logic [19:0] surf,
                          logic [23:0] thk, logic en);
    logic [CfgDataW-1:0] vals [5];
    vals = '{tl, 40'(bulk), 40'(surf), 40'(thk), 40'(en)};
    cfg_we <= 1'b1;
    foreach (vals[i]) begin
      cfg_idx <= reg_order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      chk.write_reg(reg_order[i], vals[i]);
    end
    cfg_we <= 1'b0;
    cur_tl = tl;
    cur_bulk = bulk;
    cur_surf = surf;
    cur_thick = thk;
    cur_en = en;
  endtask

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) chk.check_result(out_data);
      if (sink_hold_req > 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 11);
      end
    end
  end

  initial begin
    #36_000_000;
    $display("detector_hit_clusterer_unit regression: fail");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send(make_hit(1, 1, 0, 0, 0, 0, 0, 0));
    send(make_hit(1, 1, 0, 0, 0, 0, 0, 0));
    send(flush_req());
    send(flush_req());
    drain();

    load_cfg(40'd100, 20'd1000, 20'd300, 24'd5000, 1'b1);
    send(make_hit(5, 7, 1000, 0, 0, 0, 10000, 24'hFFFFFF));
    send(make_hit(5, 7, 1100, 500, 500, 500, 10000, 24'hFFFFFF));
    send(make_hit(5, 7, 900, -577, 0, 0, 10000, 1));
    send(make_hit(5, 7, 1000, 1000, 0, 0, 10000, 2));
    send(make_hit(5, 7, 1101, 1000, 0, 0, 10000, 3));
    send(make_hit(5, 7, 1101, 1000, 0, 0, 100, 4));
    send(make_hit(5, 7, 1101, 1299, 0, 0, 4999, 5));
    send(make_hit(5, 7, 1101, 1300, 0, 0, 4999, 6));
    send(make_hit(5, 7, 1101, 1300, 0, 0, 5000, 7));
    send(make_hit(6, 7, 1101, 1300, 0, 0, 5000, 8));
    send(make_hit(6, 8, 1101, 1300, 0, 0, 5000, 9));
    send(make_hit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 40'hFF_FFFF_FFFF, 8388607, 8388607,
                  8388607, 16777215, 16777215));
    send(make_hit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 40'hFF_FFFF_FFFF, -8388608, -8388608,
                  -8388608, 16777215, 16777215));
    send(flush_req());
    send(make_hit(9, 9, 50, 1, 2, 3, 4, 5));
    send(flush_req());
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: load_cfg('1, '1, '1, '1, 1'b1);
        2: load_cfg('0, '0, 20'd1, '1, 1'b1);
        default: load_cfg(40'($urandom_range(0, 3000)), 20'($urandom_range(0, 2000)),
                          20'($urandom_range(0, 2000)), 24'($urandom_range(0, 20000)),
                          1'($urandom_range(0, 1)));
      endcase
      no_idle = (ph == 3);
      if (ph == 0) sink_hold_req = 400;
      base = random_req();
      repeat (135) send(next_hit());
      drain();
    end

    load_cfg('1, '1, '1, '0, 1'b0);
    no_idle = 1'b1;
    repeat (270) send(make_hit(3, 4, 777, -5, 6, -7, 0, 24'hFFFFFF));
    send(flush_req());
    no_idle = 1'b0;
    drain();

    repeat (8) @(posedge clk);
    if (chk.errors == 0) begin
      $display("detector_hit_clusterer_unit regression: pass");
    end else begin
      $display("detector_hit_clusterer_unit regression: fail");
    end
    $finish;
  end

endmodule
